/* design/etmb_pkg.sv */
`timescale 1ns / 1ps
package etmb_pkg;

	// CORDIC depth and pipeline latencies
	localparam int CORDIC_STEPS = 24;
	localparam int LANE_LAT = CORDIC_STEPS + 1;
	localparam int MERGE_LAT = 4;
	localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

	localparam int XY_W = 34;
	localparam int TRIG_W = 17;
	localparam int PAIR_W = 34;
	localparam int ROT_W = 48;
	localparam int ENT_W = 24;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// arctan(2^-i), 2^32 per full turn
	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303,
		32'd651, 32'd325, 32'd162, 32'd81
	};

	typedef struct packed {
		logic signed [TRIG_W-1:0] sn;
		logic signed [TRIG_W-1:0] cs;
	} trig_t;

	typedef struct packed {
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] scale_z;
		logic [15:0] angle_a;
		logic [15:0] angle_b;
		logic [15:0] angle_g;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
	} req_t;

	typedef struct packed {
		logic signed [ENT_W-1:0] m_00;
		logic signed [ENT_W-1:0] m_01;
		logic signed [ENT_W-1:0] m_02;
		logic signed [ENT_W-1:0] m_04;
		logic signed [ENT_W-1:0] m_05;
		logic signed [ENT_W-1:0] m_06;
		logic signed [ENT_W-1:0] m_08;
		logic signed [ENT_W-1:0] m_09;
		logic signed [ENT_W-1:0] m_10;
	} mat_t;

	typedef struct packed {
		logic signed [ENT_W-1:0] m_00;
		logic signed [ENT_W-1:0] m_01;
		logic signed [ENT_W-1:0] m_02;
		logic signed [ENT_W-1:0] m_04;
		logic signed [ENT_W-1:0] m_05;
		logic signed [ENT_W-1:0] m_06;
		logic signed [ENT_W-1:0] m_08;
		logic signed [ENT_W-1:0] m_09;
		logic signed [ENT_W-1:0] m_10;
		logic signed [31:0] t_12;
		logic signed [31:0] t_13;
		logic signed [31:0] t_14;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] scale_z;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
	} side_t;

endpackage

/* design/etmb_cordic_lane.sv */
`timescale 1ns / 1ps
module etmb_cordic_lane import etmb_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] angle,
	output trig_t       trig
);

	localparam logic [31:0] AMASK = (32'd1 << ANGLE_BITS) - 32'd1;

	logic [31:0] turn;
	logic signed [XY_W-1:0] x_in [CORDIC_STEPS];
	logic signed [XY_W-1:0] y_in [CORDIC_STEPS];
	logic signed [XY_W-1:0] z_in [CORDIC_STEPS];
	logic [1:0] q_in [CORDIC_STEPS];
	logic signed [XY_W-1:0] x_s [CORDIC_STEPS];
	logic signed [XY_W-1:0] y_s [CORDIC_STEPS];
	logic signed [XY_W-1:0] z_s [CORDIC_STEPS];
	logic [1:0] q_s [CORDIC_STEPS];
	logic signed [TRIG_W-1:0] c_r, s_r;

	// scale angle to a 32-bit turn fraction
	assign turn = (32'(angle) & AMASK) << (32 - ANGLE_BITS);

	// one rotation step per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		if (i == 0) begin : g_first
			assign x_in[i] = CORDIC_GAIN;
			assign y_in[i] = '0;
			assign z_in[i] = XY_W'({2'b00, turn[29:0]});
			assign q_in[i] = turn[31:30];
		end else begin : g_next
			assign x_in[i] = x_s[i-1];
			assign y_in[i] = y_s[i-1];
			assign z_in[i] = z_s[i-1];
			assign q_in[i] = q_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i] <= q_in[i];
				if (!z_in[i][XY_W-1]) begin
					x_s[i] <= x_in[i] - (y_in[i] >>> i);
					y_s[i] <= y_in[i] + (x_in[i] >>> i);
					z_s[i] <= z_in[i] - XY_W'(ATAN_TAB[i]);
				end else begin
					x_s[i] <= x_in[i] + (y_in[i] >>> i);
					y_s[i] <= y_in[i] - (x_in[i] >>> i);
					z_s[i] <= z_in[i] + XY_W'(ATAN_TAB[i]);
				end
			end
		end
	end

	// round Q4.30 to 15 fraction bits, clamp to +-1.0
	function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] r;
		r = (v + XY_W'(16384)) >>> 15;
		if (r > XY_W'(32768))
			return TRIG_W'(32768);
		else if (r < -XY_W'(32768))
			return -TRIG_W'(32768);
		else
			return TRIG_W'(r);
	endfunction

	assign c_r = trig_round(x_s[CORDIC_STEPS-1]);
	assign s_r = trig_round(y_s[CORDIC_STEPS-1]);

	// quadrant fold
	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[CORDIC_STEPS-1])
				2'd0: begin trig.cs <= c_r;  trig.sn <= s_r;  end
				2'd1: begin trig.cs <= -s_r; trig.sn <= c_r;  end
				2'd2: begin trig.cs <= -c_r; trig.sn <= -s_r; end
				default: begin trig.cs <= s_r; trig.sn <= -c_r; end
			endcase
		end
	end

endmodule

/* design/etmb_merge.sv */
`timescale 1ns / 1ps
module etmb_merge import etmb_pkg::*; #(
	parameter int ENTRY_FRAC_BITS = 16
) (
	input  logic  clk,
	input  logic  en,
	input  trig_t trig_a,
	input  trig_t trig_b,
	input  trig_t trig_g,
	input  side_t side,
	output mat_t  mat
);

	localparam int SH = 53 - ENTRY_FRAC_BITS;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (SH - 1);
	localparam logic signed [63:0] EMAX = 64'sd8388607;
	localparam logic signed [63:0] EMIN = -64'sd8388608;

	logic signed [TRIG_W-1:0] sa, ca, sb, cb, sg, cg;
	logic signed [TRIG_W-1:0] sa_s1, ca_s1, sb_s1;
	logic signed [PAIR_W-1:0] cgcb_s1, cgsb_s1, sgca_s1, sgsa_s1, cgca_s1;
	logic signed [PAIR_W-1:0] sgsb_s1, sgcb_s1, cbsa_s1, cbca_s1, sacg_s1;
	logic signed [ROT_W-1:0] r_s2 [9];
	logic signed [63:0] p_s3 [9];
	logic signed [50:0] t1, t2, t4, t5;
	logic signed [ENT_W-1:0] e [9];

	assign sa = trig_a.sn; assign ca = trig_a.cs;
	assign sb = trig_b.sn; assign cb = trig_b.cs;
	assign sg = trig_g.sn; assign cg = trig_g.cs;

	// stage 1: pairwise trig products
	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1 <= sa; ca_s1 <= ca; sb_s1 <= sb;
			cgcb_s1 <= PAIR_W'(cg * cb);
			cgsb_s1 <= PAIR_W'(cg * sb);
			sgca_s1 <= PAIR_W'(sg * ca);
			sgsa_s1 <= PAIR_W'(sg * sa);
			cgca_s1 <= PAIR_W'(cg * ca);
			sgsb_s1 <= PAIR_W'(sg * sb);
			sgcb_s1 <= PAIR_W'(sg * cb);
			cbsa_s1 <= PAIR_W'(cb * sa);
			cbca_s1 <= PAIR_W'(cb * ca);
			sacg_s1 <= PAIR_W'(sa * cg);
		end
	end

	// stage 2: triple products and rotation terms, 45 fraction bits
	assign t1 = cgsb_s1 * sa_s1;
	assign t2 = cgsb_s1 * ca_s1;
	assign t4 = sgsb_s1 * sa_s1;
	assign t5 = sgsb_s1 * ca_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2[0] <= ROT_W'(cgcb_s1) <<< 15;
			r_s2[1] <= ROT_W'(t1) + (ROT_W'(sgca_s1) <<< 15);
			r_s2[2] <= (ROT_W'(sgsa_s1) <<< 15) - ROT_W'(t2);
			r_s2[3] <= -(ROT_W'(sgcb_s1) <<< 15);
			r_s2[4] <= (ROT_W'(cgca_s1) <<< 15) - ROT_W'(t4);
			r_s2[5] <= ROT_W'(t5) + (ROT_W'(sacg_s1) <<< 15);
			r_s2[6] <= ROT_W'(sb_s1) <<< 30;
			r_s2[7] <= -(ROT_W'(cbsa_s1) <<< 15);
			r_s2[8] <= ROT_W'(cbca_s1) <<< 15;
		end
	end

	// stage 3: apply per-axis scale
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				case (k / 3)
					0: p_s3[k] <= 64'(r_s2[k]) * 64'(side.scale_x);
					1: p_s3[k] <= 64'(r_s2[k]) * 64'(side.scale_y);
					default: p_s3[k] <= 64'(r_s2[k]) * 64'(side.scale_z);
				endcase
			end
		end
	end

	// stage 4: round half up and saturate
	always_comb begin
		logic signed [63:0] v;
		for (int k = 0; k < 9; k++) begin
			v = (p_s3[k] + HALF) >>> SH;
			if (v > EMAX)
				e[k] = ENT_W'(EMAX);
			else if (v < EMIN)
				e[k] = ENT_W'(EMIN);
			else
				e[k] = ENT_W'(v);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat.m_00 <= e[0]; mat.m_01 <= e[1]; mat.m_02 <= e[2];
			mat.m_04 <= e[3]; mat.m_05 <= e[4]; mat.m_06 <= e[5];
			mat.m_08 <= e[6]; mat.m_09 <= e[7]; mat.m_10 <= e[8];
		end
	end

endmodule

/* design/euler_transform_matrix_builder_unit.sv */
`timescale 1ns / 1ps
// channel | dir | handshake              | payload
// request | in  | req_valid / req_ready  | req (req_t)
// result  | out | rsp_valid / rsp_ready  | rsp (rsp_t)
//
// One request per cycle while no result is held; each result passes through
// 24 CORDIC stages, a trig round and 4 product/round stages.
// The three angle lanes run in parallel and feed one shared product merge.
// Reset clears only the stage valid bits.
// A held result stalls the whole pipeline, and req_ready drops with it.
module euler_transform_matrix_builder_unit import etmb_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int ENTRY_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic adv;
	logic [TOTAL_LAT-1:0] vld_q;
	side_t side_q [TOTAL_LAT];
	side_t side_in;
	trig_t trig_a, trig_b, trig_g;
	mat_t mat;

	// advance unless the output holds a result not yet taken
	assign adv = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], req_valid};
		end
	end

	// scales and offsets travel alongside the lanes
	assign side_in = '{scale_x: req.scale_x, scale_y: req.scale_y, scale_z: req.scale_z,
		offset_x: req.offset_x, offset_y: req.offset_y, offset_z: req.offset_z};

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_in;
			for (int k = 1; k < TOTAL_LAT; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	etmb_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_a (
		.clk(clk), .en(adv), .angle(req.angle_a), .trig(trig_a));
	etmb_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_b (
		.clk(clk), .en(adv), .angle(req.angle_b), .trig(trig_b));
	etmb_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_g (
		.clk(clk), .en(adv), .angle(req.angle_g), .trig(trig_g));

	etmb_merge #(.ENTRY_FRAC_BITS(ENTRY_FRAC_BITS)) u_merge (
		.clk(clk), .en(adv), .trig_a(trig_a), .trig_b(trig_b), .trig_g(trig_g),
		.side(side_q[LANE_LAT+1]), .mat(mat));

	// result assembly
	assign rsp_valid = vld_q[TOTAL_LAT-1];
	assign rsp = '{m_00: mat.m_00, m_01: mat.m_01, m_02: mat.m_02,
		m_04: mat.m_04, m_05: mat.m_05, m_06: mat.m_06,
		m_08: mat.m_08, m_09: mat.m_09, m_10: mat.m_10,
		t_12: side_q[TOTAL_LAT-1].offset_x, t_13: side_q[TOTAL_LAT-1].offset_y,
		t_14: side_q[TOTAL_LAT-1].offset_z};

	// pipeline freezes while a result is held
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(vld_q))
		else $error("pipeline moved under a held result");

	// lane b trig values of a live request stay within +-1.0
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LANE_LAT-1] |->
		(trig_b.sn <= 17'sd32768 && trig_b.sn >= -17'sd32768 &&
		trig_b.cs <= 17'sd32768 && trig_b.cs >= -17'sd32768))
		else $error("trig value out of range");

	// a new result comes from the stage before it
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(vld_q[TOTAL_LAT-2]))
		else $error("result without a source stage");

endmodule

/* sim/tb_euler_transform_matrix_builder_unit.sv */
`timescale 1ns / 1ps
module tb_euler_transform_matrix_builder_unit;
	import etmb_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	rsp_t expected_mats[$];
	int n_errors;
	int n_sent;
	int n_checked;
	bit sink_stall_on;
	bit hold_sink;
	bit src_gaps_on;

	localparam int LAT = 29;

	euler_transform_matrix_builder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// arctan(2^-i), 2^32 per full turn
	localparam longint ARCTAN [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41721, 20860, 10430, 5215,
		2607, 1303, 651, 325, 162, 81
	};

	// >>> on longint floors for negative values
	function automatic longint round_trig(longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32768) r = 32768;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	// quadrant fold plus 24-step CORDIC on a 16-bit binary angle
	function automatic void cordic_sin_cos(input logic [15:0] ang, output longint sn,
			output longint cs);
		logic [31:0] turn;
		longint x, y, z, dx, dy, c, s;
		turn = {ang, 16'h0000};
		z = longint'(turn[29:0]);
		x = 652032874;
		y = 0;
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		c = round_trig(x);
		s = round_trig(y);
		case (turn[31:30])
			2'd0: begin cs = c; sn = s; end
			2'd1: begin cs = -s; sn = c; end
			2'd2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endfunction

	// 45-bit-fraction rotation term times Q8.8 scale, rounded and saturated
	function automatic logic [23:0] scaled_entry(longint r, logic signed [15:0] sc);
		longint p, v;
		p = r * longint'(sc);
		v = (p + (longint'(1) << 36)) >>> 37;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function automatic rsp_t build_matrix(req_t q);
		longint sa, ca, sb, cb, sg, cg;
		longint k;
		rsp_t m;
		k = 32768;
		cordic_sin_cos(q.angle_a, sa, ca);
		cordic_sin_cos(q.angle_b, sb, cb);
		cordic_sin_cos(q.angle_g, sg, cg);
		m.m_00 = scaled_entry(cg * cb * k, q.scale_x);
		m.m_01 = scaled_entry(cg * sb * sa + sg * ca * k, q.scale_x);
		m.m_02 = scaled_entry(sg * sa * k - cg * sb * ca, q.scale_x);
		m.m_04 = scaled_entry(-sg * cb * k, q.scale_y);
		m.m_05 = scaled_entry(cg * ca * k - sg * sb * sa, q.scale_y);
		m.m_06 = scaled_entry(sg * sb * ca + sa * cg * k, q.scale_y);
		m.m_08 = scaled_entry(sb * k * k, q.scale_z);
		m.m_09 = scaled_entry(-cb * sa * k, q.scale_z);
		m.m_10 = scaled_entry(cb * ca * k, q.scale_z);
		m.t_12 = q.offset_x;
		m.t_13 = q.offset_y;
		m.t_14 = q.offset_z;
		return m;
	endfunction

	// send one request, with an optional random gap first
	task automatic send_request(input req_t q);
		int gap;
		if (src_gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= q;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		expected_mats.push_back(build_matrix(q));
		n_sent++;
	endtask

	function automatic req_t random_request();
		req_t q;
		q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		// mostly modest scales so entries do not all saturate
		if ($urandom_range(0, 3) != 0) begin
			q.scale_x = 16'($signed($urandom_range(0, 2048)) - 1024);
			q.scale_y = 16'($signed($urandom_range(0, 2048)) - 1024);
			q.scale_z = 16'($signed($urandom_range(0, 2048)) - 1024);
		end
		return q;
	endfunction

	// result receiver: random stall bursts, or a long hold-off on request
	initial begin
		int burst;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				rsp_ready <= 1'b0;
				repeat (120) @(posedge clk);
				hold_sink = 1'b0;
			end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12);
				rsp_ready <= 1'b0;
				repeat (burst) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rsp_t exp_m;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_mats.size() == 0) begin
				$display("%0t: unexpected result %h", $time, rsp);
				n_errors++;
			end else begin
				exp_m = expected_mats.pop_front();
				n_checked++;
				if (rsp !== exp_m) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_m, rsp);
					if (rsp.m_00 !== exp_m.m_00) $display("  m_00 exp %0d got %0d", exp_m.m_00, rsp.m_00);
					if (rsp.m_01 !== exp_m.m_01) $display("  m_01 exp %0d got %0d", exp_m.m_01, rsp.m_01);
					if (rsp.m_02 !== exp_m.m_02) $display("  m_02 exp %0d got %0d", exp_m.m_02, rsp.m_02);
					if (rsp.m_04 !== exp_m.m_04) $display("  m_04 exp %0d got %0d", exp_m.m_04, rsp.m_04);
					if (rsp.m_05 !== exp_m.m_05) $display("  m_05 exp %0d got %0d", exp_m.m_05, rsp.m_05);
					if (rsp.m_06 !== exp_m.m_06) $display("  m_06 exp %0d got %0d", exp_m.m_06, rsp.m_06);
					if (rsp.m_08 !== exp_m.m_08) $display("  m_08 exp %0d got %0d", exp_m.m_08, rsp.m_08);
					if (rsp.m_09 !== exp_m.m_09) $display("  m_09 exp %0d got %0d", exp_m.m_09, rsp.m_09);
					if (rsp.m_10 !== exp_m.m_10) $display("  m_10 exp %0d got %0d", exp_m.m_10, rsp.m_10);
					if (rsp.t_12 !== exp_m.t_12) $display("  t_12 exp %0d got %0d", exp_m.t_12, rsp.t_12);
					if (rsp.t_13 !== exp_m.t_13) $display("  t_13 exp %0d got %0d", exp_m.t_13, rsp.t_13);
					if (rsp.t_14 !== exp_m.t_14) $display("  t_14 exp %0d got %0d", exp_m.t_14, rsp.t_14);
					n_errors++;
				end
			end
		end
	end

	// extremes: quadrant edges, octants, full-scale and zero scales
	task automatic test_directed();
		logic [15:0] angs [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'h2000, 16'hFFFF, 16'h0001, 16'h7FFF};
		req_t q;
		for (int i = 0; i < 8; i++) begin
			q.scale_x = 16'sh0100; q.scale_y = 16'sh0100; q.scale_z = 16'sh0100;
			q.angle_a = angs[i]; q.angle_b = angs[(i + 3) % 8];
			q.angle_g = angs[(i + 5) % 8];
			q.offset_x = 32'sh7FFFFFFF; q.offset_y = 32'sh80000000;
			q.offset_z = 32'sh00000000;
			send_request(q);
		end
		// saturating scales both ways, negative scale mirrors
		for (int i = 0; i < 8; i++) begin
			q.scale_x = (i[0]) ? 16'sh7FFF : 16'sh8000;
			q.scale_y = (i[1]) ? 16'sh8000 : 16'sh7FFF;
			q.scale_z = (i[2]) ? 16'shFF00 : 16'sh0000;
			q.angle_a = angs[i]; q.angle_b = angs[7 - i]; q.angle_g = 16'h2000;
			q.offset_x = 32'shFFFFFFFF; q.offset_y = 32'sh00000001;
			q.offset_z = 32'sh80000000;
			send_request(q);
		end
		q = '1;
		send_request(q);
		q = '0;
		send_request(q);
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) send_request(random_request());
	endtask

	// receiver holds off long enough to fill the pipeline and stall input
	task automatic test_backpressure();
		hold_sink = 1'b1;
		test_random(80);
	endtask

	initial begin
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		sink_stall_on = 1'b0;
		src_gaps_on = 1'b0;
		hold_sink = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		sink_stall_on = 1'b1;
		src_gaps_on = 1'b1;
		test_random(1200);
		test_backpressure();
		// final stretch at full rate, no idling
		sink_stall_on = 1'b0;
		src_gaps_on = 1'b0;
		test_random(600);
		req_valid <= 1'b0;

		while (expected_mats.size() != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
		$display("covered %0d requests (%0d results checked): quadrant edges,", n_sent,
			n_checked);
		$display("saturating and negative scales, random stalls and a long hold-off");
		if (n_errors == 0) begin
			$display("tb_euler_transform_matrix_builder_unit: done, clean");
		end else begin
			$display("tb_euler_transform_matrix_builder_unit: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", expected_mats.size());
		$display("tb_euler_transform_matrix_builder_unit: done, errors");
		$finish;
	end

endmodule
